@@ design/dtdt_pkg.sv @@
// Shared types and constants for the deadline-to-ticks pipeline.
`default_nettype none
package dtdt_pkg;
  localparam int unsigned DIV_W = 30;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TIMED_OUT = 2'd1,
    ST_INVALID   = 2'd2
  } status_e;

  localparam logic REG_TICK_RATE   = 1'b0;
  localparam logic REG_NS_PER_TICK = 1'b1;

  // One request in flight through the divider stages.
  typedef struct packed {
    logic [63:0]      sec;
    status_e          status;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] quo;
    logic [DIV_W:0]   rem;
  } div_t;
endpackage
`default_nettype wire

@@ design/dtdt_front.sv @@
// Time compare and exact seconds/nanoseconds subtraction with borrow.
`default_nettype none
module dtdt_front import dtdt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [63:0] dl_sec_i,
  input  wire logic [31:0] dl_ns_i,
  input  wire logic [63:0] now_sec_i,
  input  wire logic [31:0] now_ns_i,
  output logic             valid_o,
  output div_t             item_o
);
  logic        valid_q;
  div_t        item_d, item_q;
  logic [63:0] sec_diff;
  logic [32:0] ns_diff, ns_fix;
  logic [63:0] sec_fix;
  logic        sec_lt, sec_eq, ns_lt, ns_eq;

  always_comb begin
    // deadline is not earlier here, so the 64-bit difference is exact
    sec_diff = dl_sec_i - now_sec_i;
    ns_diff  = {dl_ns_i[31], dl_ns_i} - {now_ns_i[31], now_ns_i};
    sec_lt   = $signed(dl_sec_i) < $signed(now_sec_i);
    sec_eq   = dl_sec_i == now_sec_i;
    ns_lt    = $signed(dl_ns_i) < $signed(now_ns_i);
    ns_eq    = dl_ns_i == now_ns_i;
    // borrow one second when the nanosecond difference goes negative
    if (ns_diff[32]) begin
      sec_fix = sec_diff - 64'd1;
      ns_fix  = ns_diff + {3'b000, NS_PER_SEC};
    end else begin
      sec_fix = sec_diff;
      ns_fix  = ns_diff;
    end
    item_d        = '0;
    item_d.status = ST_OK;
    if (sec_lt || (sec_eq && ns_lt)) begin
      item_d.status = ST_TIMED_OUT;
    end else if (sec_eq && ns_eq) begin
      item_d.status = ST_OK;
    end else if (ns_fix[32] || (ns_fix[31:0] >= {2'b00, NS_PER_SEC})) begin
      item_d.status = ST_INVALID;
    end else begin
      item_d.sec = sec_fix;
      item_d.num = ns_fix[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule
`default_nettype wire

@@ design/dtdt_div.sv @@
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module dtdt_div import dtdt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  input  wire logic             valid_i,
  input  wire div_t             item_i,
  output logic                  valid_o,
  output div_t                  item_o
);
  logic [DIV_W-1:0] vld_q;
  div_t             st_q [DIV_W];
  logic [DIV_W:0]   dvs;

  // zero divisor acts as one
  assign dvs = (divisor_i == '0) ? {{DIV_W{1'b0}}, 1'b1} : {1'b0, divisor_i};

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    div_t           src, nxt;
    logic           src_vld;
    logic [DIV_W:0] trial;

    if (k == 0) begin : g_first
      assign src     = item_i;
      assign src_vld = valid_i;
    end else begin : g_next
      assign src     = st_q[k-1];
      assign src_vld = vld_q[k-1];
    end

    always_comb begin
      nxt     = src;
      trial   = {src.rem[DIV_W-1:0], src.num[DIV_W-1]};
      nxt.num = {src.num[DIV_W-2:0], 1'b0};
      if (trial >= dvs) begin
        nxt.rem = trial - dvs;
        nxt.quo = {src.quo[DIV_W-2:0], 1'b1};
      end else begin
        nxt.rem = trial;
        nxt.quo = {src.quo[DIV_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[DIV_W-1];
  assign item_o  = st_q[DIV_W-1];
endmodule
`default_nettype wire

@@ design/dtdt_mul.sv @@
// Seconds-by-rate multiply in two halves, final sum and range check.
`default_nettype none
module dtdt_mul import dtdt_pkg::*; #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [29:0] rate_i,
  input  wire logic        valid_i,
  input  wire div_t        item_i,
  output logic             valid_o,
  output logic [31:0]      ticks_o,
  output logic [1:0]       status_o
);
  localparam logic [94:0] LIMIT = (TICK_WIDTH >= 64) ? {32'd0, 63'h7FFF_FFFF_FFFF_FFFF}
                                                     : ((95'd1 << TICK_WIDTH) - 95'd1);

  logic        a_vld_q, b_vld_q;
  logic [61:0] plo_q, phi_q;
  logic [DIV_W:0] nt_d, nt_q;
  status_e     st_a_q, st_b_d, st_b_q;
  logic [94:0] total;
  logic [31:0] ticks_d, ticks_q;

  // round the nanosecond quotient up
  assign nt_d = {1'b0, item_i.quo} + {{DIV_W{1'b0}}, (item_i.rem != '0)};

  always_comb begin
    total   = {1'b0, phi_q, 32'd0} + {33'd0, plo_q} + {{(95-DIV_W-1){1'b0}}, nt_q};
    st_b_d  = st_a_q;
    ticks_d = '0;
    if (st_a_q == ST_OK) begin
      if (total > LIMIT) begin
        st_b_d = ST_INVALID;
      end else begin
        ticks_d = total[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q   <= {30'd0, item_i.sec[31:0]} * {32'd0, rate_i};
      phi_q   <= {30'd0, item_i.sec[63:32]} * {32'd0, rate_i};
      nt_q    <= nt_d;
      st_a_q  <= item_i.status;
      st_b_q  <= st_b_d;
      ticks_q <= ticks_d;
    end
  end

  assign valid_o  = b_vld_q;
  assign ticks_o  = ticks_q;
  assign status_o = st_b_q;
endmodule
`default_nettype wire

@@ design/deadline_to_delta_ticks_core.sv @@
// Top level: deadline minus now, converted to ticks.
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, deadline/now s+ns | request in
//  out     | out_valid_o, out_stall_i, ticks_o, status_o| result out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | register write
//
// One request per cycle while out_stall_i does not hold the pipeline; stages in order: compare/subtract stage,
// 30 divider stages (one quotient bit each), multiply stage, sum/check stage.
// Reset clears all valid bits and loads rate 1000, 1000000 ns per tick.
// A held result stalls the whole pipeline in place; nothing is dropped.
`default_nettype none
module deadline_to_delta_ticks_core import dtdt_pkg::*; #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [29:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] deadline_seconds_i,
  input  wire logic [31:0] deadline_nanoseconds_i,
  input  wire logic [63:0] now_seconds_i,
  input  wire logic [31:0] now_nanoseconds_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      ticks_o,
  output logic [1:0]       status_o
);
  logic [29:0] rate_q, npt_q;
  logic        en;
  logic        f_vld, d_vld;
  div_t        f_item, d_item;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 30'd1000;
      npt_q  <= 30'd1000000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICK_RATE:   rate_q <= cfg_data_i;
        REG_NS_PER_TICK: npt_q  <= cfg_data_i;
        default:         rate_q <= rate_q;
      endcase
    end
  end

  dtdt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .dl_sec_i  (deadline_seconds_i),
    .dl_ns_i   (deadline_nanoseconds_i),
    .now_sec_i (now_seconds_i),
    .now_ns_i  (now_nanoseconds_i),
    .valid_o   (f_vld),
    .item_o    (f_item)
  );

  dtdt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .divisor_i (npt_q),
    .valid_i   (f_vld),
    .item_i    (f_item),
    .valid_o   (d_vld),
    .item_o    (d_item)
  );

  dtdt_mul #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .rate_i   (rate_q),
    .valid_i  (d_vld),
    .item_i   (d_item),
    .valid_o  (out_valid_o),
    .ticks_o  (ticks_o),
    .status_o (status_o)
  );
endmodule
`default_nettype wire

@@ tb/sv/tb_deadline_to_delta_ticks_core.sv @@
// Self-checking testbench for the deadline-to-ticks conversion core.
`timescale 1ns / 1ps
`default_nettype none
module tb_deadline_to_delta_ticks_core;
  import dtdt_pkg::*;

  localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SMIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] TOP64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 45;

  typedef struct {
    longint ds;
    int     dn;
    longint ns;
    int     nn;
  } req_t;

  typedef struct {
    logic [31:0] ticks;
    status_e     status;
  } rsp_t;

  class tick_scoreboard;
    rsp_t        pending_q[$];
    logic [29:0] rate_hz;
    logic [29:0] ns_tick;
    int          mismatches;

    function new();
      rate_hz = 30'd1000;
      ns_tick = 30'd1000000;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [29:0] val);
      if (idx == REG_TICK_RATE) rate_hz = val;
      else ns_tick = val;
    endfunction

    function rsp_t convert(req_t r);
      rsp_t        e;
      logic [63:0] sec, npt, nsd_ticks, prod, total;
      longint      nsd;
      logic        ovf;
      e.ticks = '0;
      e.status = ST_OK;
      if (r.ds < r.ns || (r.ds == r.ns && r.dn < r.nn)) begin
        e.status = ST_TIMED_OUT;
      end else if (r.ds != r.ns || r.dn != r.nn) begin
        sec = r.ds - r.ns;
        nsd = longint'(r.dn) - longint'(r.nn);
        // borrow one second
        if (nsd < 0) begin
          sec = sec - 64'd1;
          nsd = nsd + 64'sd1000000000;
        end
        if (nsd < 0 || nsd >= 64'sd1000000000) begin
          e.status = ST_INVALID;
        end else begin
          npt = (ns_tick == '0) ? 64'd1 : 64'(ns_tick);
          nsd_ticks = (64'(nsd) + npt - 64'd1) / npt;
          ovf = 1'b0;
          prod = '0;
          if (rate_hz != '0) begin
            if (sec > TOP64 / 64'(rate_hz)) ovf = 1'b1;
            else prod = sec * 64'(rate_hz);
          end
          if (!ovf && prod > TOP64 - nsd_ticks) ovf = 1'b1;
          total = prod + nsd_ticks;
          if (ovf || total > 64'hFFFF_FFFF) begin
            e.status = ST_INVALID;
          end else begin
            e.ticks = total[31:0];
          end
        end
      end
      return e;
    endfunction

    function void note_request(req_t r);
      pending_q.push_back(convert(r));
    endfunction

    function void check_result(logic [31:0] ticks, logic [1:0] status);
      rsp_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ticks=%0d status=%0d", ticks, status);
        return;
      end
      e = pending_q.pop_front();
      if (ticks !== e.ticks || status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp ticks=%0d status=%0d, got ticks=%0d status=%0d",
                   e.ticks, e.status, ticks, status);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [29:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] deadline_seconds_i;
  logic [31:0] deadline_nanoseconds_i;
  logic [63:0] now_seconds_i;
  logic [31:0] now_nanoseconds_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] ticks_o;
  logic [1:0]  status_o;

  deadline_to_delta_ticks_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .deadline_seconds_i, .deadline_nanoseconds_i, .now_seconds_i, .now_nanoseconds_i,
    .out_valid_o, .out_stall_i, .ticks_o, .status_o
  );

  tick_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Result side: random stall and checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) sb.check_result(ticks_o, status_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    deadline_seconds_i <= r.ds;
    deadline_nanoseconds_i <= r.dn;
    now_seconds_i <= r.ns;
    now_nanoseconds_i <= r.nn;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // caller drops the write enable after the last write
  task automatic write_reg(logic idx, logic [29:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  function automatic longint rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int rand_ns();
    return $urandom_range(999999999);
  endfunction

  function automatic req_t random_request();
    req_t   r;
    longint delta;
    int     kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      r.ds = rand64(); r.dn = $urandom(); r.ns = rand64(); r.nn = $urandom();
      return r;
    end
    case ($urandom_range(4))
      0: delta = 0;
      1: delta = longint'($urandom_range(3));
      2: delta = longint'($urandom_range(1 << 20));
      3: delta = {32'd0, $urandom()};
      default: delta = rand64();
    endcase
    r.ns = ($urandom_range(1)) ? rand64() : longint'($urandom_range(1000000));
    r.ds = r.ns + delta;
    r.dn = rand_ns();
    r.nn = rand_ns();
    // break the nanosecond field now and then
    if (kind == 1) begin
      if ($urandom_range(1)) r.dn = $urandom();
      else r.nn = $urandom();
    end
    if (kind == 2) begin
      r.ds = r.ns;
      r.nn = r.dn + $urandom_range(1000);
    end
    if ($urandom_range(7) == 0) begin
      longint t;
      t = r.ds; r.ds = r.ns; r.ns = t;
    end
    return r;
  endfunction

  task automatic run_directed();
    req_t d[$];
    d.push_back('{0, 0, 0, 0});
    d.push_back('{5, -7, 5, -7});
    d.push_back('{-1, 0, 0, 0});
    d.push_back('{10, 5, 10, 6});
    d.push_back('{SMAX, 0, SMIN, 0});
    d.push_back('{SMIN, 0, SMAX, 0});
    d.push_back('{2, 0, 1, 999999999});
    d.push_back('{3, 1999999999, 1, 0});
    d.push_back('{3, -1500000000, 1, 0});
    d.push_back('{1, 32'h7FFF_FFFF, 0, 32'h8000_0000});
    d.push_back('{0, 1, 0, 0});
    d.push_back('{0, 999999999, 0, 0});
    d.push_back('{4294967, 0, 0, 0});
    d.push_back('{4294968, 0, 0, 0});
    d.push_back('{1, 0, 0, 0});
    d.push_back('{SMAX, 999999999, SMAX - 1, 0});
    d.push_back('{-5, 0, SMIN, 0});
    d.push_back('{-1, -1, -1, -1});
    foreach (d[i]) send_request(d[i]);
  endtask

  initial begin
    logic [29:0] rates[6];
    logic [29:0] npts[6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TICK_RATE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    deadline_seconds_i = '0;
    deadline_nanoseconds_i = '0;
    now_seconds_i = '0;
    now_nanoseconds_i = '0;
    rates = '{30'd1000, 30'd1, 30'd1000000000, 30'd0, 30'h3FFF_FFFF, 30'd0};
    npts = '{30'd1000000, 30'd1, 30'd1000000000, 30'd0, 30'h3FFF_FFFF, 30'd0};
    rates[5] = 30'($urandom_range(1, 1000000));
    npts[5] = 30'($urandom_range(1, 1000000000));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        write_reg(REG_TICK_RATE, rates[ph]);
        write_reg(REG_NS_PER_TICK, npts[ph]);
        cfg_we_i <= 1'b0;
      end
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 63; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 63; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      run_directed();
      for (int k = 0; k < 125; k++) send_request(random_request());
      drain();
    end
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
